/* sv/tkz_pkg.sv */
// ---------------------------------------------------------------------------
// tkz_pkg
// Shared constants, token record and operator classification for the
// charstring tokenizer.
// ---------------------------------------------------------------------------
`default_nettype none
package tkz_pkg;

	localparam int OPD    = 32;
	localparam int OPA_W  = $clog2(OPD);
	localparam int OPD_W  = $clog2(OPD + 1);
	localparam int SCD    = 16;
	localparam int SCA_W  = $clog2(SCD);
	localparam int SCD_W  = $clog2(SCD + 1);

	localparam logic [2:0] K_NUM   = 3'd0;
	localparam logic [2:0] K_ENTRY = 3'd1;
	localparam logic [2:0] K_OP    = 3'd2;
	localparam logic [2:0] K_SUBR  = 3'd3;
	localparam logic [2:0] K_RET   = 3'd4;
	localparam logic [2:0] K_ERR   = 3'd5;

	localparam logic [2:0] E_NONE  = 3'd0;
	localparam logic [2:0] E_UNK   = 3'd1;
	localparam logic [2:0] E_TRUNC = 3'd2;
	localparam logic [2:0] E_UNDER = 3'd3;
	localparam logic [2:0] E_OVER  = 3'd4;
	localparam logic [2:0] E_DIV0  = 3'd5;

	localparam logic [2:0] C_DUMP = 3'd0;
	localparam logic [2:0] C_END  = 3'd1;
	localparam logic [2:0] C_SUBR = 3'd2;
	localparam logic [2:0] C_RET  = 3'd3;
	localparam logic [2:0] C_DIV  = 3'd4;
	localparam logic [2:0] C_OSR  = 3'd5;
	localparam logic [2:0] C_POP  = 3'd6;
	localparam logic [2:0] C_BAD  = 3'd7;

	localparam logic [7:0] B_ESCAPE   = 8'd12;
	localparam logic [7:0] B_OPS_END  = 8'd32;
	localparam logic [7:0] B_NUM1_MAX = 8'd246;
	localparam logic [7:0] B_LONG     = 8'd255;
	localparam logic [7:0] B_POS_BASE = 8'd247;
	localparam logic [7:0] B_POS_MAX  = 8'd250;
	localparam logic [7:0] B_NEG_BASE = 8'd251;
	localparam logic [10:0] NUM2_BIAS = 11'd108;
	localparam logic [31:0] NUM1_BIAS = 32'd139;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] value;
		logic [4:0]         op;
		logic               esc;
		logic [5:0]         depth;
		logic [2:0]         err;
		logic               last;
	} tok_t;

	function automatic tok_t mk_tok(input logic [2:0] kind, input logic [31:0] value,
			input logic [4:0] op, input logic esc, input logic [OPD_W-1:0] depth,
			input logic [2:0] err, input logic last);
		tok_t t;
		t.kind  = kind;
		t.value = value;
		t.op    = op;
		t.esc   = esc;
		t.depth = 6'(depth);
		t.err   = err;
		t.last  = last;
		return t;
	endfunction

	function automatic logic [2:0] op_class(input logic [7:0] b, input logic esc);
		logic [2:0] c;
		c = C_BAD;
		if (!esc) begin
			case (b)
				8'd1, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9,
				8'd13, 8'd21, 8'd22, 8'd30, 8'd31: c = C_DUMP;
				8'd14: c = C_END;
				8'd10: c = C_SUBR;
				8'd11: c = C_RET;
				default: c = C_BAD;
			endcase
		end else begin
			case (b)
				8'd0, 8'd1, 8'd2, 8'd6, 8'd7, 8'd33: c = C_DUMP;
				8'd12: c = C_DIV;
				8'd16: c = C_OSR;
				8'd17: c = C_POP;
				default: c = C_BAD;
			endcase
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* sv/tkz_if.sv */
// ---------------------------------------------------------------------------
// tkz_req_if / tkz_tok_if
// Valid/ready channels for charstring bytes and result tokens.
// ---------------------------------------------------------------------------
`default_nettype none
interface tkz_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       first_of_string;
	logic       end_of_string;
	modport source(output valid, code_byte, first_of_string, end_of_string, input ready);
	modport sink(input valid, code_byte, first_of_string, end_of_string, output ready);
endinterface

interface tkz_tok_if;
	logic               valid;
	logic               ready;
	logic [2:0]         token_kind;
	logic signed [31:0] value;
	logic [4:0]         op_code;
	logic               op_escaped;
	logic [5:0]         depth_now;
	logic [2:0]         error_code;
	logic               last_of_run;
	modport source(output valid, token_kind, value, op_code, op_escaped, depth_now,
		error_code, last_of_run, input ready);
	modport sink(input valid, token_kind, value, op_code, op_escaped, depth_now,
		error_code, last_of_run, output ready);
endinterface
`default_nettype wire

/* sv/tkz_div.sv */
// ---------------------------------------------------------------------------
// tkz_div
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero,
// saturating the single positive overflow case.
// ---------------------------------------------------------------------------
`default_nettype none
module tkz_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] dvd,
	input  wire logic signed [31:0] dvs,
	output logic                    busy,
	output logic signed [31:0]      quo
);
	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [32:0] rem_q;
	logic [31:0] qm_q;
	logic [31:0] dvs_q;
	logic        neg_q;
	logic [32:0] rem_sh;
	logic [33:0] diff;
	logic        ge;

	assign rem_sh = {rem_q[31:0], qm_q[31]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign ge     = !diff[33];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd31;
		end else if (busy_q) begin
			if (cnt_q == 5'd0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			qm_q  <= dvd[31] ? -dvd : dvd;
			dvs_q <= dvs[31] ? -dvs : dvs;
			neg_q <= dvd[31] ^ dvs[31];
		end else if (busy_q) begin
			rem_q <= ge ? diff[32:0] : rem_sh;
			qm_q  <= {qm_q[30:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = neg_q ? -qm_q : (qm_q[31] ? 32'h7fff_ffff : qm_q);
endmodule
`default_nettype wire

/* sv/type1_charstring_tokenizer.sv */
// ---------------------------------------------------------------------------
// type1_charstring_tokenizer
// Decodes Type 1 charstring bytes into number, stack, operator, subroutine
// and error tokens; operand and script stacks live in synchronous RAMs.
// ---------------------------------------------------------------------------
// channel | dir | payload
// req     | in  | code_byte, first_of_string, end_of_string
// tok     | out | token_kind, value, op_code, op_escaped, depth_now,
//         |     | error_code, last_of_run
//
// One request at a time: a byte is accepted in S_IDLE and decoded in S_EXEC.
// Stack dump: each entry is read from the operand RAM (S_DUMP_RD), then emitted (S_DUMP_EM).
// callsubr and pop go through S_RD1 and S_RD2; div adds S_RD3 and S_DIV (one quotient bit per cycle);
// callothersubr adds S_RD3, then S_OSR_RD and S_OSR_WR for each argument.
// Token register frees the input side while the last token waits; a stalled
// tok channel holds the sequencer. No clearing pass after reset.
// ---------------------------------------------------------------------------
`default_nettype none
module type1_charstring_tokenizer (
	input wire logic clk,
	input wire logic arst_n,
	tkz_req_if.sink  req,
	tkz_tok_if.source tok
);
	import tkz_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_EXEC    = 4'd1;
	localparam logic [3:0] S_RD1     = 4'd2;
	localparam logic [3:0] S_RD2     = 4'd3;
	localparam logic [3:0] S_RD3     = 4'd4;
	localparam logic [3:0] S_DIV     = 4'd5;
	localparam logic [3:0] S_OSR_RD  = 4'd6;
	localparam logic [3:0] S_OSR_WR  = 4'd7;
	localparam logic [3:0] S_DUMP_RD = 4'd8;
	localparam logic [3:0] S_DUMP_EM = 4'd9;

	logic [31:0] op_mem [OPD];
	logic [31:0] sc_mem [SCD];

	logic [3:0]       st_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic [OPD_W-1:0] depth_q;
	logic [SCD_W-1:0] sdepth_q;
	logic [7:0]       lead_q;
	logic [23:0]      part_q;
	logic [2:0]       pend_q;
	logic             esc_q;
	logic             ended_q;
	logic             err_q;
	logic [2:0]       cls_q;
	logic [4:0]       opc_q;
	logic             opesc_q;
	logic [OPD_W-1:0] cnt_q;
	logic [OPD_W-1:0] nargs_q;
	logic [31:0]      bval_q;
	logic [31:0]      rd_q;
	logic [31:0]      srd_q;
	tok_t             tok_q;
	logic             tokv_q;

	logic             out_free;
	logic             halted;
	logic             pend_nz;
	logic             cont_more;
	logic             do_push;
	logic             do_op;
	logic             full;
	logic [2:0]       cls;
	logic [10:0]      tp;
	logic [10:0]      tn;
	logic [31:0]      pv;
	logic [OPA_W-1:0] ra;
	logic             op_we;
	logic [OPA_W-1:0] op_wa;
	logic [31:0]      op_wd;
	logic             sc_we;
	logic             div_start;
	logic             div_busy;
	logic signed [31:0] div_q;
	logic             cnt_big;
	logic [OPD_W-1:0] osr_n;
	logic [OPD_W-1:0] dm2;
	logic             sc_over;

	assign out_free  = !tokv_q || tok.ready;
	assign halted    = ended_q || err_q;
	assign pend_nz   = pend_q != 3'd0;
	assign cont_more = (lead_q == B_LONG) && (pend_q > 3'd1);
	assign do_push   = pend_nz ? !cont_more
		: (!esc_q && byte_q >= B_OPS_END && byte_q <= B_NUM1_MAX);
	assign do_op     = !pend_nz && (esc_q || (byte_q < B_OPS_END && byte_q != B_ESCAPE));
	assign full      = depth_q == OPD_W'(OPD);
	assign cls       = op_class(byte_q, esc_q);
	assign tp        = {1'b0, 2'(lead_q - B_POS_BASE), byte_q} + NUM2_BIAS;
	assign tn        = {1'b0, 2'(lead_q - B_NEG_BASE), byte_q} + NUM2_BIAS;
	assign pv        = !pend_nz ? ({24'd0, byte_q} - NUM1_BIAS)
		: (lead_q == B_LONG) ? {part_q, byte_q}
		: (lead_q <= B_POS_MAX) ? 32'(tp) : -32'(tn);

	assign dm2     = depth_q - OPD_W'(2);
	assign cnt_big = !rd_q[31] && (rd_q > 32'(dm2));
	assign osr_n   = rd_q[31] ? '0 : rd_q[OPD_W-1:0];
	assign sc_over = (8'(sdepth_q) + 8'(osr_n)) > 8'(SCD);

	always_comb begin
		case (st_q)
			S_RD2:     ra = ((cls_q == C_DIV) || (cls_q == C_OSR)) ?
				OPA_W'(dm2) : OPA_W'(depth_q - OPD_W'(1));
			S_RD3:     ra = OPA_W'(dm2);
			S_OSR_RD:  ra = OPA_W'(depth_q - OPD_W'(3) - cnt_q);
			S_DUMP_RD: ra = OPA_W'(cnt_q);
			S_DUMP_EM: ra = OPA_W'(cnt_q);
			default:   ra = OPA_W'(depth_q - OPD_W'(1));
		endcase
	end

	always_comb begin
		op_we = 1'b0;
		op_wa = OPA_W'(depth_q);
		op_wd = pv;
		case (st_q)
			S_EXEC: op_we = out_free && !halted && do_push && !full;
			S_RD2: begin
				op_we = out_free && (cls_q == C_POP);
				op_wd = srd_q;
			end
			S_DIV: begin
				op_we = out_free && !div_busy;
				op_wa = OPA_W'(dm2);
				op_wd = div_q;
			end
			default: op_we = 1'b0;
		endcase
	end

	assign sc_we     = st_q == S_OSR_WR;
	assign div_start = (st_q == S_RD3) && out_free && (cls_q == C_DIV) && (bval_q != 32'd0);

	always_ff @(posedge clk) begin
		if (op_we) op_mem[op_wa] <= op_wd;
		rd_q <= op_mem[ra];
		if (sc_we) sc_mem[SCA_W'(sdepth_q)] <= rd_q;
		srd_q <= sc_mem[SCA_W'(sdepth_q - SCD_W'(1))];
	end

	tkz_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (rd_q),
		.dvs    (bval_q),
		.busy   (div_busy),
		.quo    (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			depth_q  <= '0;
			sdepth_q <= '0;
			lead_q   <= '0;
			part_q   <= '0;
			pend_q   <= '0;
			esc_q    <= 1'b0;
			ended_q  <= 1'b0;
			err_q    <= 1'b0;
			tokv_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (tok.ready) tokv_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (req.valid) begin
						byte_q <= req.code_byte;
						last_q <= req.end_of_string;
						if (req.first_of_string) begin
							ended_q  <= 1'b0;
							err_q    <= 1'b0;
							depth_q  <= '0;
							sdepth_q <= '0;
							pend_q   <= '0;
							esc_q    <= 1'b0;
							lead_q   <= '0;
							part_q   <= '0;
						end
						st_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						st_q <= S_IDLE;
						if (halted) begin
							st_q <= S_IDLE;
						end else if (do_push) begin
							pend_q <= '0;
							tokv_q <= 1'b1;
							if (full) begin
								tok_q <= mk_tok(K_ERR, pv, 5'd0, 1'b0, depth_q, E_OVER, 1'b1);
								err_q <= 1'b1;
								esc_q <= 1'b0;
							end else begin
								depth_q <= depth_q + OPD_W'(1);
								tok_q <= mk_tok(K_NUM, pv, 5'd0, 1'b0, depth_q + OPD_W'(1),
									E_NONE, 1'b1);
							end
						end else if (do_op) begin
							esc_q   <= 1'b0;
							cls_q   <= cls;
							opc_q   <= byte_q[4:0];
							opesc_q <= esc_q;
							cnt_q   <= '0;
							case (cls)
								C_DUMP, C_END: st_q <= S_DUMP_RD;
								C_SUBR, C_DIV, C_OSR: begin
									if (depth_q < ((cls == C_SUBR) ? OPD_W'(1) : OPD_W'(2))) begin
										tokv_q <= 1'b1;
										err_q  <= 1'b1;
										tok_q  <= mk_tok(K_ERR, 32'd0, byte_q[4:0], esc_q, depth_q,
											E_UNDER, 1'b1);
									end else begin
										st_q <= S_RD1;
									end
								end
								C_POP: begin
									if (sdepth_q == '0 || full) begin
										tokv_q <= 1'b1;
										err_q  <= 1'b1;
										tok_q  <= mk_tok(K_ERR, 32'd0, byte_q[4:0], 1'b1, depth_q,
											(sdepth_q == '0) ? E_UNDER : E_OVER, 1'b1);
									end else begin
										st_q <= S_RD1;
									end
								end
								C_RET: begin
									tokv_q <= 1'b1;
									tok_q  <= mk_tok(K_RET, 32'd0, byte_q[4:0], 1'b0, depth_q,
										E_NONE, 1'b1);
								end
								default: begin
									tokv_q <= 1'b1;
									err_q  <= 1'b1;
									tok_q  <= mk_tok(K_ERR, 32'd0, byte_q[4:0], esc_q, depth_q,
										E_UNK, 1'b1);
								end
							endcase
						end else if (pend_nz) begin
							part_q <= {part_q[15:0], byte_q};
							pend_q <= pend_q - 3'd1;
							if (last_q) begin
								pend_q <= '0;
								tokv_q <= 1'b1;
								err_q  <= 1'b1;
								tok_q  <= mk_tok(K_ERR, 32'd0, 5'd0, 1'b0, depth_q, E_TRUNC, 1'b1);
							end
						end else if (byte_q == B_ESCAPE) begin
							if (last_q) begin
								tokv_q <= 1'b1;
								err_q  <= 1'b1;
								tok_q  <= mk_tok(K_ERR, 32'd0, B_ESCAPE[4:0], 1'b0, depth_q,
									E_TRUNC, 1'b1);
							end else begin
								esc_q <= 1'b1;
							end
						end else begin
							lead_q <= byte_q;
							part_q <= '0;
							pend_q <= (byte_q == B_LONG) ? 3'd4 : 3'd1;
							if (last_q) begin
								pend_q <= '0;
								tokv_q <= 1'b1;
								err_q  <= 1'b1;
								tok_q  <= mk_tok(K_ERR, 32'd0, 5'd0, 1'b0, depth_q, E_TRUNC, 1'b1);
							end
						end
					end
				end
				S_RD1: st_q <= S_RD2;
				S_RD2: begin
					case (cls_q)
						C_SUBR: begin
							if (out_free) begin
								depth_q <= depth_q - OPD_W'(1);
								tokv_q  <= 1'b1;
								tok_q   <= mk_tok(K_SUBR, rd_q, opc_q, 1'b0,
									depth_q - OPD_W'(1), E_NONE, 1'b1);
								st_q    <= S_IDLE;
							end
						end
						C_POP: begin
							if (out_free) begin
								depth_q  <= depth_q + OPD_W'(1);
								sdepth_q <= sdepth_q - SCD_W'(1);
								tokv_q   <= 1'b1;
								tok_q    <= mk_tok(K_OP, srd_q, opc_q, 1'b1,
									depth_q + OPD_W'(1), E_NONE, 1'b1);
								st_q     <= S_IDLE;
							end
						end
						default: begin
							bval_q <= rd_q;
							st_q   <= S_RD3;
						end
					endcase
				end
				S_RD3: begin
					if (out_free) begin
						if (cls_q == C_DIV) begin
							if (bval_q == 32'd0) begin
								tokv_q <= 1'b1;
								err_q  <= 1'b1;
								tok_q  <= mk_tok(K_ERR, 32'd0, opc_q, 1'b1, depth_q, E_DIV0, 1'b1);
								st_q   <= S_IDLE;
							end else begin
								st_q <= S_DIV;
							end
						end else if (cnt_big || sc_over) begin
							tokv_q <= 1'b1;
							err_q  <= 1'b1;
							tok_q  <= mk_tok(K_ERR, 32'd0, opc_q, 1'b1, depth_q,
								cnt_big ? E_UNDER : E_OVER, 1'b1);
							st_q   <= S_IDLE;
						end else begin
							nargs_q <= osr_n;
							cnt_q   <= '0;
							st_q    <= S_OSR_RD;
						end
					end
				end
				S_DIV: begin
					if (out_free && !div_busy) begin
						depth_q <= depth_q - OPD_W'(1);
						tokv_q  <= 1'b1;
						tok_q   <= mk_tok(K_OP, div_q, opc_q, 1'b1, depth_q - OPD_W'(1),
							E_NONE, 1'b1);
						st_q    <= S_IDLE;
					end
				end
				S_OSR_RD: begin
					if (cnt_q == nargs_q) begin
						if (out_free) begin
							depth_q <= dm2 - nargs_q;
							tokv_q  <= 1'b1;
							tok_q   <= mk_tok(K_OP, bval_q, opc_q, 1'b1, dm2 - nargs_q,
								E_NONE, 1'b1);
							st_q    <= S_IDLE;
						end
					end else begin
						st_q <= S_OSR_WR;
					end
				end
				S_OSR_WR: begin
					sdepth_q <= sdepth_q + SCD_W'(1);
					cnt_q    <= cnt_q + OPD_W'(1);
					st_q     <= S_OSR_RD;
				end
				S_DUMP_RD: begin
					if (cnt_q == depth_q) begin
						if (out_free) begin
							depth_q <= '0;
							tokv_q  <= 1'b1;
							tok_q   <= mk_tok(K_OP, 32'd0, opc_q, opesc_q, depth_q, E_NONE, 1'b1);
							if (cls_q == C_END) ended_q <= 1'b1;
							st_q    <= S_IDLE;
						end
					end else begin
						st_q <= S_DUMP_EM;
					end
				end
				S_DUMP_EM: begin
					if (out_free) begin
						tokv_q <= 1'b1;
						tok_q  <= mk_tok(K_ENTRY, rd_q, 5'd0, 1'b0, depth_q, E_NONE, 1'b0);
						cnt_q  <= cnt_q + OPD_W'(1);
						st_q   <= S_DUMP_RD;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready       = st_q == S_IDLE;
	assign tok.valid       = tokv_q;
	assign tok.token_kind  = tok_q.kind;
	assign tok.value       = tok_q.value;
	assign tok.op_code     = tok_q.op;
	assign tok.op_escaped  = tok_q.esc;
	assign tok.depth_now   = tok_q.depth;
	assign tok.error_code  = tok_q.err;
	assign tok.last_of_run = tok_q.last;
endmodule
`default_nettype wire
